// ===== hw/rtl/brig_pkg.sv =====
// brig_pkg: shared types and constants for the bounded random integer generator
// used by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package brig_pkg;

    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;

    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;
    localparam logic [1:0] REG_SEED = 2'd2;
    localparam logic [1:0] REG_INC  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic reload;      // state <= seed + inc
        logic check;       // evaluate range, latch bound
        logic div_start;   // start 32-bit remainder unit
        logic div_use_r;   // 1: dividend is r, 0: dividend is -bound
        logic div_step;    // one restoring step
        logic thr_load;    // latch remainder as threshold
        logic mul_step;    // one partial-product step of the lcg multiply
        logic mul_start;   // clear multiply accumulator
        logic lcg_commit;  // state <= product + inc, form permuted word
        logic out_load;    // latch result word
        logic out_err;     // result is a range error
        logic out_equal;   // result is range_low
    } brig_cmd_t;

    typedef struct packed {
        logic err;         // low > high or bound wrapped
        logic equal;       // low == high
        logic div_done;    // last remainder step taken
        logic mul_done;    // last multiply step taken
        logic reject;      // permuted word below threshold
    } brig_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_random_integer_gen_top.sv =====
// bounded_random_integer_gen_top: apb register file, stream handshake and glue
// depends on brig_pkg, brig_ctrl, brig_out, brig_datapath
`timescale 1ns / 1ps
`default_nettype none

// pcg32 (xsh-rr) generator giving one uniform integer in range_low..range_high
// inclusive per input word. a word with restart set reloads the lcg state with
// seed + (increment | 1) first. the state advances through a 64 x 16 serial
// multiplier (partial-product steps, then a commit and a test state per draw),
// and the rejection threshold and final remainder each come from a 32-step
// restoring remainder unit; a rejected draw is followed by a new one. an equal
// or invalid range goes from the range check to the output state, without
// stepping the generator. one request is in flight at a time; the result sits
// in an output register and the next word is taken only once that result has
// been taken. registers: 0 range_low, 1 range_high, 2 seed_value,
// 3 stream_increment, at byte addresses 8*i, 64-bit data.

module bounded_random_integer_gen_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] rand_value
    output logic             m_tuser,    // [0] range_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import brig_pkg::*;

    logic [31:0] low_reg, high_reg;
    logic [63:0] seed_reg, inc_reg;
    logic [1:0]  ridx;
    brig_cmd_t   cmd_c, cmd_d;
    brig_sts_t   sts;
    logic        thr_take;
    logic        to_out;
    logic        div_last;

    assign pready = 1'b1;
    assign ridx   = paddr[4:3];

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= 32'd0;
            high_reg <= 32'd1;
            seed_reg <= 64'd0;
            inc_reg  <= 64'd1;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (ridx)
                REG_LOW:  low_reg  <= pwdata[31:0];
                REG_HIGH: high_reg <= pwdata[31:0];
                REG_SEED: seed_reg <= pwdata;
                REG_INC:  inc_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_LOW:  prdata = {32'd0, low_reg};
            REG_HIGH: prdata = {32'd0, high_reg};
            REG_SEED: prdata = seed_reg;
            REG_INC:  prdata = inc_reg;
            default:  prdata = 64'd0;
        endcase
    end

    brig_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cmd        (cmd_c),
        .sts        (sts)
    );

    // threshold latch at the end of the first remainder pass, result load on leaving the
    // second pass or on the shortcut from the range check
    assign div_last = cmd_c.div_step && sts.div_done;
    assign to_out   = (div_last && !thr_take) || (cmd_c.check && (sts.err || sts.equal));

    brig_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_in    (cmd_c),
        .last_step (div_last),
        .to_out    (to_out),
        .cmd_out   (cmd_d),
        .thr_take  (thr_take)
    );

    brig_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd_d),
        .sts              (sts),
        .range_low        (low_reg),
        .range_high       (high_reg),
        .seed_value       (seed_reg),
        .stream_increment (inc_reg),
        .rand_value       (m_tdata),
        .range_error      (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/brig_datapath.sv =====
// brig_datapath: lcg state, serial multiplier, restoring remainder unit and result register
// depends on brig_pkg
`timescale 1ns / 1ps
`default_nettype none

module brig_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire brig_pkg::brig_cmd_t cmd,
    output brig_pkg::brig_sts_t     sts,
    input  wire logic [31:0]        range_low,
    input  wire logic [31:0]        range_high,
    input  wire logic [63:0]        seed_value,
    input  wire logic [63:0]        stream_increment,
    output logic [31:0]             rand_value,
    output logic                    range_error
);
    import brig_pkg::*;

    logic [63:0] state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  mcnt_reg, mcnt_next;
    logic [31:0] bound_reg, bound_next;
    logic [31:0] thr_reg, thr_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] quo_reg, quo_next;   // dividend shifting out
    logic [32:0] rem_reg, rem_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [31:0] val_reg, val_next;
    logic        err_reg, err_next;

    logic [63:0] inc;
    logic [63:0] lcg;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [32:0] trial;
    logic [31:0] b_calc;
    logic [15:0] mpart;
    logic [63:0] pp;

    assign inc    = stream_increment | 64'd1;
    assign b_calc = range_high - range_low + 32'd1;
    assign lcg    = acc_reg + inc;
    assign xs     = 32'((((lcg >> 18) ^ lcg) >> 27));
    assign rot    = lcg[63:59];
    assign trial  = {rem_reg[31:0], quo_reg[31]} - {1'b0, bound_reg};

    // 64 x 16 partial product per step, four steps
    always_comb begin
        mpart = LCG_MULT[16*mcnt_reg +: 16];
        pp    = (state_reg * {48'd0, mpart}) << (16 * mcnt_reg);
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        mcnt_next  = mcnt_reg;
        bound_next = bound_reg;
        thr_next   = thr_reg;
        r_next     = r_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        val_next   = val_reg;
        err_next   = err_reg;
        if (cmd.reload) state_next = seed_value + inc;
        if (cmd.check) bound_next = b_calc;
        if (cmd.mul_start) begin
            acc_next  = 64'd0;
            mcnt_next = 2'd0;
        end
        if (cmd.mul_step) begin
            acc_next  = acc_reg + pp;
            mcnt_next = mcnt_reg + 2'd1;
        end
        if (cmd.lcg_commit) begin
            state_next = lcg;
            r_next     = (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));
        end
        if (cmd.div_start) begin
            // bound is taken straight from the range registers, it is latched in the same cycle
            quo_next  = cmd.div_use_r ? r_reg : (32'd0 - b_calc);
            rem_next  = 33'd0;
            dcnt_next = 5'd0;
        end
        if (cmd.div_step) begin
            if (!trial[32]) rem_next = trial;
            else rem_next = {rem_reg[31:0], quo_reg[31]};
            quo_next  = quo_reg << 1;
            dcnt_next = dcnt_reg + 5'd1;
        end
        // loads come with the last remainder step, so take the remainder after that step
        if (cmd.thr_load) thr_next = rem_next[31:0];
        if (cmd.out_load) begin
            err_next = cmd.out_err;
            if (cmd.out_err) val_next = 32'd0;
            else if (cmd.out_equal) val_next = range_low;
            else val_next = rem_next[31:0] + range_low;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= 64'd1;
            mcnt_reg  <= 2'd0;
            dcnt_reg  <= 5'd0;
        end else begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            dcnt_reg  <= dcnt_next;
        end
        acc_reg   <= acc_next;
        bound_reg <= bound_next;
        thr_reg   <= thr_next;
        r_reg     <= r_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        val_reg   <= val_next;
        err_reg   <= err_next;
    end

    always_comb begin
        sts.err      = ($signed(range_low) > $signed(range_high)) || (b_calc == 32'd0);
        sts.equal    = (range_low == range_high);
        sts.div_done = (dcnt_reg == 5'd31) && cmd.div_step;
        sts.mul_done = (mcnt_reg == 2'd3) && cmd.mul_step;
        sts.reject   = (r_reg < thr_reg);
    end

    assign rand_value  = val_reg;
    assign range_error = err_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/brig_ctrl.sv =====
// brig_ctrl: sequencing state machine for one request
// depends on brig_pkg
`timescale 1ns / 1ps
`default_nettype none

module brig_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic                in_restart,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output brig_pkg::brig_cmd_t      cmd,
    input  wire brig_pkg::brig_sts_t sts
);
    import brig_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_THR, ST_MUL, ST_COMMIT, ST_TEST, ST_MOD, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   busy;

    assign busy      = (state_reg != ST_IDLE) && (state_reg != ST_OUT);
    // the result register is shared, so a new word waits until the last result has gone
    assign in_ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready) ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.reload = in_restart;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.err || sts.equal) begin
                    cmd.out_err   = sts.err;
                    cmd.out_equal = sts.equal;
                    state_next    = ST_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_THR;
                end
            end
            ST_THR: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = ST_MUL;
                cmd.mul_start = sts.div_done;
            end
            ST_MUL: begin
                if (!ovalid_reg || !busy) cmd.thr_load = 1'b0;
                cmd.mul_step = 1'b1;
                if (sts.mul_done) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.lcg_commit = 1'b1;
                state_next     = ST_TEST;
            end
            ST_TEST: begin
                if (sts.reject) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_use_r = 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ovalid_reg || out_ready) begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/brig_out.sv =====
// brig_out: command staging; forms the threshold and result load commands and holds the range flags for the result
// depends on brig_pkg
`timescale 1ns / 1ps
`default_nettype none

module brig_out (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire brig_pkg::brig_cmd_t cmd_in,
    input  wire logic                last_step,
    input  wire logic                to_out,
    output brig_pkg::brig_cmd_t      cmd_out,
    output logic                     thr_take
);
    import brig_pkg::*;

    logic        flag_reg, flag_next;  // 1 while a threshold remainder is in flight
    logic        err_reg, err_next;
    logic        eq_reg, eq_next;

    always_comb begin
        flag_next = flag_reg;
        err_next  = err_reg;
        eq_next   = eq_reg;
        cmd_out   = cmd_in;
        if (cmd_in.check) begin
            err_next  = cmd_in.out_err;
            eq_next   = cmd_in.out_equal;
            flag_next = !(cmd_in.out_err || cmd_in.out_equal);
        end
        thr_take = flag_reg && last_step;
        if (thr_take) flag_next = 1'b0;
        cmd_out.thr_load = thr_take;
        cmd_out.out_load = to_out;
        // the shortcut loads in the check cycle itself, before the flags are registered
        cmd_out.out_err   = cmd_in.check ? cmd_in.out_err : err_reg;
        cmd_out.out_equal = cmd_in.check ? cmd_in.out_equal : eq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
            err_reg  <= 1'b0;
            eq_reg   <= 1'b0;
        end else begin
            flag_reg <= flag_next;
            err_reg  <= err_next;
            eq_reg   <= eq_next;
        end
    end

endmodule

`default_nettype wire
